### src/pcwm_pkg.sv
package pcwm_pkg;

    // Block dimensions
    localparam int CHANNELS    = 8;
    localparam int WINDOW      = 100;
    localparam int SAMPLE_BITS = 32;

    // Field and state widths
    localparam int CH_BITS    = 3;
    localparam int FILL_BITS  = 7;
    localparam int PTR_BITS   = $clog2(WINDOW);
    localparam int SUM_BITS   = SAMPLE_BITS + FILL_BITS;
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int ADDR_BITS  = $clog2(RING_DEPTH);
    localparam int CNT_BITS   = $clog2(SUM_BITS + 1);

    typedef struct packed {
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel_out;
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [FILL_BITS-1:0]          fill;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_ABS,
        ST_DIV,
        ST_SIGN,
        ST_DONE
    } state_t;

endpackage

### src/per_channel_windowed_mean.sv
// Steps, in order, once a sample transaction is accepted:
// ring read, sum update, magnitude, 39-step bit-serial restoring divide, sign fix, output load.
// A new sample is taken only after the previous result has been loaded for output.
// An out-of-range channel skips the sum update and divide and returns mean and fill of zero.
// Reset (rst_n, async, active low) clears the per-channel pointers, fill counts
// and sums; the sample ring is not cleared, as a slot's value is used only once written.
module per_channel_windowed_mean
    import pcwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  in_item_t  sample_item,
    output logic      mean_valid,
    input  logic      mean_ready,
    output out_item_t mean_item
);

    // Control state
    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  mean_valid_reg;

    // Per-channel state
    logic [PTR_BITS-1:0]        ptr_reg  [CHANNELS];
    logic [FILL_BITS-1:0]       fill_reg [CHANNELS];
    logic signed [SUM_BITS-1:0] sum_reg  [CHANNELS];

    // Transaction payload
    logic [CH_BITS-1:0]         ch_reg;
    logic [SAMPLE_BITS-1:0]     samp_reg;
    logic [ADDR_BITS-1:0]       addr_reg;
    logic signed [SUM_BITS-1:0] acc_reg;
    logic                       neg_reg;
    logic [SUM_BITS-1:0]        dvd_reg;
    logic [FILL_BITS-1:0]       rem_reg;
    logic [FILL_BITS-1:0]       div_reg;
    logic [SAMPLE_BITS-1:0]     res_mean_reg;
    logic [FILL_BITS-1:0]       res_fill_reg;
    out_item_t                  out_reg;

    // Sample ring
    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    // Control strobes
    logic                   accept;
    logic                   in_range;
    logic                   ring_we;
    logic                   out_load;
    logic [ADDR_BITS-1:0]   rd_addr;

    // Datapath helpers
    logic                       full;
    logic signed [SUM_BITS-1:0] samp_ext;
    logic signed [SUM_BITS-1:0] old_ext;
    logic signed [SUM_BITS-1:0] acc_new;
    logic [FILL_BITS-1:0]       fill_new;
    logic [PTR_BITS-1:0]        ptr_new;
    logic [FILL_BITS:0]         trial;
    logic                       qbit;
    logic [FILL_BITS-1:0]       rem_next;
    logic [SUM_BITS-1:0]        quot_signed;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_UPDATE : ST_DONE;
                end
            end
            ST_UPDATE: state_next = ST_ABS;
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        sample_ready = (state_reg == ST_IDLE);
        accept       = sample_valid && sample_ready;
        in_range     = ({1'b0, sample_item.channel} < (CH_BITS + 1)'(CHANNELS));
        ring_we      = (state_reg == ST_UPDATE);
        out_load     = (state_reg == ST_DONE) && (!mean_valid_reg || mean_ready);
    end

    // Ring address of the slot under the channel's pointer
    assign rd_addr = ADDR_BITS'(sample_item.channel) * ADDR_BITS'(WINDOW)
                   + ADDR_BITS'(ptr_reg[sample_item.channel]);

    // Sum update: new sample in, oldest sample out once the window is full
    assign samp_ext = {{(SUM_BITS - SAMPLE_BITS){sample_item.sample[SAMPLE_BITS-1]}},
                       sample_item.sample};
    assign old_ext  = {{(SUM_BITS - SAMPLE_BITS){rdata_reg[SAMPLE_BITS-1]}}, rdata_reg};
    assign full     = (fill_reg[ch_reg] >= FILL_BITS'(WINDOW));
    assign acc_new  = full ? (acc_reg - old_ext) : acc_reg;
    assign fill_new = full ? FILL_BITS'(WINDOW) : (fill_reg[ch_reg] + 1'b1);
    assign ptr_new  = (ptr_reg[ch_reg] == PTR_BITS'(WINDOW - 1)) ? '0
                                                                   : (ptr_reg[ch_reg] + 1'b1);

    // One restoring divide step per cycle
    assign trial    = {rem_reg, dvd_reg[SUM_BITS-1]};
    assign qbit     = (trial >= {1'b0, div_reg});
    assign rem_next = qbit ? FILL_BITS'(trial - {1'b0, div_reg}) : FILL_BITS'(trial);

    assign quot_signed = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;

    // Control registers and per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            mean_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ptr_reg[i]  <= '0;
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ABS)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_UPDATE)
            begin
                ptr_reg[ch_reg]  <= ptr_new;
                fill_reg[ch_reg] <= fill_new;
                sum_reg[ch_reg]  <= acc_new;
            end
            if (out_load)
            begin
                mean_valid_reg <= 1'b1;
            end
            else if (mean_ready)
            begin
                mean_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_reg       <= sample_item.channel;
                    samp_reg     <= sample_item.sample;
                    addr_reg     <= rd_addr;
                    acc_reg      <= sum_reg[sample_item.channel] + samp_ext;
                    res_mean_reg <= '0;
                    res_fill_reg <= '0;
                end
            end
            ST_UPDATE:
            begin
                acc_reg      <= acc_new;
                res_fill_reg <= fill_new;
                div_reg      <= fill_new;
            end
            ST_ABS:
            begin
                neg_reg <= acc_reg[SUM_BITS-1];
                dvd_reg <= acc_reg[SUM_BITS-1] ? SUM_BITS'(-acc_reg) : SUM_BITS'(acc_reg);
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                dvd_reg <= {dvd_reg[SUM_BITS-2:0], qbit};
                rem_reg <= rem_next;
            end
            ST_SIGN:
            begin
                res_mean_reg <= quot_signed[SAMPLE_BITS-1:0];
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg.channel_out <= ch_reg;
            out_reg.mean        <= res_mean_reg;
            out_reg.fill        <= res_fill_reg;
        end
    end

    // Sample ring: read at acceptance, written during the sum update
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[addr_reg] <= samp_reg;
        end
        if (accept)
        begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    assign mean_valid = mean_valid_reg;
    assign mean_item  = out_reg;

`ifndef ASSERT_OFF
    // Pointer of an accepted channel stays inside its window
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range) |-> (ptr_reg[sample_item.channel] < PTR_BITS'(WINDOW)))
        else $error("ring pointer out of window");

    // Fill count never passes the window length
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (fill_reg[ch_reg] <= FILL_BITS'(WINDOW)))
        else $error("fill count exceeds window");

    // Divider step counter stays within the dividend width
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_BITS'(SUM_BITS)))
        else $error("divider ran too many steps");

    // Quotient magnitude fits the mean field
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> (dvd_reg[SUM_BITS-1:SAMPLE_BITS] == '0))
        else $error("quotient overflows mean width");

    // A finished result waits while the output register is still full
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && mean_valid_reg && !mean_ready)
        |=> (state_reg == ST_DONE && mean_valid_reg))
        else $error("result dropped while output stalled");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import pcwm_pkg::*;

    localparam int RANDOM_ITEMS   = 1230;
    localparam int SEG_ITEMS      = 160;
    localparam int TAIL_ITEMS     = 120;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 20;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Directed row: fixed rows carry a hand-computed result, others use the predictor
    typedef struct packed {
        logic [CH_BITS-1:0]     ch;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   fixed;
        logic [SAMPLE_BITS-1:0] mean;
        logic [FILL_BITS-1:0]   fill;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{3'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd1},
        '{3'd1, 32'h8000_0000, 1'b1, 32'h8000_0000, 7'd1},
        '{3'd2, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 7'd1},
        '{3'd2, 32'h0000_0000, 1'b1, 32'h0000_0000, 7'd2},  // -1/2 truncates to zero
        '{3'd3, 32'h0000_0003, 1'b1, 32'h0000_0003, 7'd1},
        '{3'd3, 32'hFFFF_FFFC, 1'b1, 32'h0000_0000, 7'd2},  // -1/2
        '{3'd3, 32'hFFFF_FFFC, 1'b1, 32'hFFFF_FFFF, 7'd3},  // -5/3 -> -1
        '{3'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd2},
        '{3'd1, 32'h8000_0000, 1'b1, 32'h8000_0000, 7'd2},
        '{3'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 7'd3},
        '{3'd4, 32'h0001_0000, 1'b1, 32'h0001_0000, 7'd1},
        '{3'd5, 32'h5555_5555, 1'b1, 32'h5555_5555, 7'd1},
        '{3'd5, 32'hAAAA_AAAA, 1'b0, 32'h0,         7'd0},
        '{3'd6, 32'h0000_FFFF, 1'b1, 32'h0000_FFFF, 7'd1},
        '{3'd7, 32'hFFFF_0000, 1'b1, 32'hFFFF_0000, 7'd1},
        '{3'd7, 32'h0001_0001, 1'b0, 32'h0,         7'd0},
        '{3'd1, 32'h7FFF_FFFF, 1'b0, 32'h0,         7'd0},
        '{3'd4, 32'hFFFF_FFFF, 1'b0, 32'h0,         7'd0},
        '{3'd2, 32'h8000_0000, 1'b0, 32'h0,         7'd0},
        '{3'd6, 32'h0000_0000, 1'b0, 32'h0,         7'd0}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_ready;
    in_item_t  sample_item = '0;
    logic      mean_valid;
    logic      mean_ready = 1'b0;
    out_item_t mean_item;

    // Predictor state, one window per channel
    logic signed [SAMPLE_BITS-1:0] win_ring [CHANNELS][WINDOW];
    int     win_ptr  [CHANNELS] = '{default: 0};
    int     win_fill [CHANNELS] = '{default: 0};
    longint win_sum  [CHANNELS] = '{default: 0};

    out_item_t mean_expected [$];
    out_item_t mean_head;

    int  send_idle_pct = 20;
    int  recv_idle_pct = 20;
    bit  quiet_tail = 1'b0;
    bit  holdoff_done = 1'b0;
    int  holdoff_left = 0;
    int  stall_left = 0;
    int  stuck_cycles = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  full_windows = 0;
    int  mismatches = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    per_channel_windowed_mean DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .mean_valid   (mean_valid),
        .mean_ready   (mean_ready),
        .mean_item    (mean_item)
    );

    // Push one sample into the predicted windows and return the mean it produces
    function automatic out_item_t advance_window(input in_item_t item);
        out_item_t res;
        int        ch;
        int        slot;
        longint    avg;
        ch = int'(item.channel);
        res.channel_out = item.channel;
        res.mean = '0;
        res.fill = '0;
        if (ch >= CHANNELS)
            return res;
        slot = win_ptr[ch];
        // full window: oldest sample sits under the pointer
        if (win_fill[ch] >= WINDOW)
        begin
            win_sum[ch] -= longint'(win_ring[ch][slot]);
            full_windows++;
        end
        else
        begin
            win_fill[ch]++;
        end
        win_ring[ch][slot] = item.sample;
        win_sum[ch] += longint'(item.sample);
        win_ptr[ch] = (slot + 1 == WINDOW) ? 0 : slot + 1;
        avg = win_sum[ch] / longint'(win_fill[ch]);
        res.mean = avg[SAMPLE_BITS-1:0];
        res.fill = FILL_BITS'(win_fill[ch]);
        return res;
    endfunction

    // Offer one sample; on acceptance record its expected mean, then maybe idle
    task automatic send_sample(input in_item_t item, input bit use_fixed,
                               input out_item_t fixed_res);
        out_item_t predicted;
        int        gap;
        sample_item  <= item;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        predicted = advance_window(item);
        if (use_fixed)
            predicted = fixed_res;
        mean_expected.insert(mean_expected.size(), predicted);
        samples_sent++;
        if (!quiet_tail && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result check and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && mean_valid && mean_ready)
        begin
            results_seen++;
            if (mean_expected.size() == 0)
            begin
                $error("unexpected transaction: channel_out %0d mean %0d fill %0d",
                       mean_item.channel_out, mean_item.mean, mean_item.fill);
                mismatches++;
            end
            else
            begin
                mean_head = mean_expected.pop_front();
                if (mean_item.channel_out !== mean_head.channel_out)
                begin
                    $error("channel_out: expected %0d, got %0d",
                           mean_head.channel_out, mean_item.channel_out);
                    mismatches++;
                end
                if (mean_item.mean !== mean_head.mean)
                begin
                    $error("mean: expected %0d, got %0d", mean_head.mean, mean_item.mean);
                    mismatches++;
                end
                if (mean_item.fill !== mean_head.fill)
                begin
                    $error("fill: expected %0d, got %0d", mean_head.fill, mean_item.fill);
                    mismatches++;
                end
            end
        end

        // one long hold-off so the block backs up into its input
        if (!holdoff_done && results_seen >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
        end

        if (holdoff_left > 0)
        begin
            holdoff_left--;
            mean_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            mean_ready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(99) < recv_idle_pct)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            mean_ready <= 1'b0;
        end
        else
        begin
            mean_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (mean_valid && mean_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        in_item_t  item;
        out_item_t fixed_res;
        int        seg;
        int        hot;
        int        kind;

        seg = 0;
        hot = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, rounding toward zero, fresh windows
        foreach (dir_rows[i])
        begin
            item.channel          = dir_rows[i].ch;
            item.sample           = dir_rows[i].smp;
            fixed_res.channel_out = dir_rows[i].ch;
            fixed_res.mean        = dir_rows[i].mean;
            fixed_res.fill        = dir_rows[i].fill;
            send_sample(item, dir_rows[i].fixed, fixed_res);
        end

        // random: one hot channel per segment so windows wrap many times
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % SEG_ITEMS == 0)
            begin
                seg = k / SEG_ITEMS;
                hot = seg % CHANNELS;
                if (seg % 3 == 1)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else
                begin
                    send_idle_pct = $urandom_range(5, 40);
                    recv_idle_pct = $urandom_range(5, 40);
                end
            end
            if (k == RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;
            // sender pause until all outstanding means are back
            if (k == RANDOM_ITEMS / 2)
            begin
                sample_valid <= 1'b0;
                while (mean_expected.size() != 0)
                    @(posedge clk);
            end

            if ($urandom_range(99) < 70)
                item.channel = CH_BITS'(hot);
            else
                item.channel = CH_BITS'($urandom_range((1 << CH_BITS) - 1));

            kind = $urandom_range(99);
            if (kind < 8)
                item.sample = SAMPLE_MAX;
            else if (kind < 16)
                item.sample = SAMPLE_MIN;
            else if (kind < 40)
                item.sample = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            else
                item.sample = $urandom;

            // saturate the hot window at both ends to stress the sum width
            if (seg == 4 && item.channel == CH_BITS'(hot))
                item.sample = SAMPLE_MAX;
            if (seg == 5 && item.channel == CH_BITS'(hot))
                item.sample = SAMPLE_MIN;

            send_sample(item, 1'b0, '0);
        end

        sample_valid <= 1'b0;
        while (mean_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d samples sent, %0d means checked, %0d with a full window",
                 samples_sent, results_seen, full_windows);
        $display("Summary: one long output hold-off, one drain pause, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
